### rtl/cgsa_pkg.sv
// Package with the shared types, codes and field widths of the clipped grid accumulator.
`default_nettype none
package cgsa_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;

    localparam int REQ_W      = 2;
    localparam int IDX_W      = 12;
    localparam int CELL_W     = 16;
    localparam int POS_W      = 9;
    localparam int MAG_W      = 16;
    localparam int SIDE_W     = 7;
    localparam int CENTER_W   = 6;
    localparam int CTR_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int LIN_W      = 14;
    localparam int OFS_W      = 10;
    localparam int PROD_W     = CELL_W + MAG_W;
    localparam int RND_SHIFT  = 12;
    localparam int TERM_W     = PROD_W + 1 - RND_SHIFT;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_STAMP  = 2'd2,
        REQ_GATHER = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH      = 3'd0,
        CFG_GRID_HEIGHT     = 3'd1,
        CFG_GRID_CENTER_X   = 3'd2,
        CFG_GRID_CENTER_Y   = 3'd3,
        CFG_STREAM_WIDTH    = 3'd4,
        CFG_STREAM_HEIGHT   = 3'd5,
        CFG_STREAM_CENTER_X = 3'd6,
        CFG_STREAM_CENTER_Y = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESOLVE,
        S_FETCH,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic resolve;
        logic fetch;
        logic commit;
    } cmd_t;

endpackage
`default_nettype wire

### rtl/cgsa_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module cgsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/cgsa_ctrl.sv
// Sequencer that steps each accepted transfer through resolve, fetch and commit.
`default_nettype none
module cgsa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output cgsa_pkg::cmd_t  cmd
);
    import cgsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/cgsa_datapath.sv
// Datapath with configuration, stream counters, address resolution and the scaled add.
`default_nettype none
module cgsa_datapath #(
    parameter int MAX_SIDE   = cgsa_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = cgsa_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cgsa_pkg::cmd_t                         cmd,
    input  logic                                   cfg_wr_en,
    input  logic [cgsa_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [cgsa_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic [cgsa_pkg::REQ_W-1:0]             req_type,
    input  logic [cgsa_pkg::IDX_W-1:0]             cell_index,
    input  logic signed [cgsa_pkg::CELL_W-1:0]     cell_value,
    input  logic signed [cgsa_pkg::POS_W-1:0]      pos_x,
    input  logic signed [cgsa_pkg::POS_W-1:0]      pos_y,
    input  logic signed [cgsa_pkg::MAG_W-1:0]      magnitude,
    input  logic                                   last_cell,
    output logic signed [cgsa_pkg::CELL_W-1:0]     read_value,
    output logic                                   landed,
    output logic                                   saturated,
    output logic                                   done
);
    import cgsa_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SUM_W  = ((VALUE_BITS > TERM_W) ? VALUE_BITS : TERM_W) + 1;
    localparam int EXT_W  = SUM_W - VALUE_BITS + 1;

    logic [SIDE_W-1:0]   grid_width_reg;
    logic [SIDE_W-1:0]   grid_height_reg;
    logic [CENTER_W-1:0] grid_center_x_reg;
    logic [CENTER_W-1:0] grid_center_y_reg;
    logic [SIDE_W-1:0]   stream_width_reg;
    logic [SIDE_W-1:0]   stream_height_reg;
    logic [CENTER_W-1:0] stream_center_x_reg;
    logic [CENTER_W-1:0] stream_center_y_reg;
    logic [CTR_W-1:0]    stream_col_reg;
    logic [CTR_W-1:0]    stream_row_reg;
    logic [CTR_W-1:0]    stream_col_next;
    logic [CTR_W-1:0]    stream_row_next;

    req_t                     req_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [CELL_W-1:0] val_reg;
    logic signed [POS_W-1:0]  px_reg;
    logic signed [POS_W-1:0]  py_reg;
    logic signed [MAG_W-1:0]  mag_reg;
    logic                     last_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        addr_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [CELL_W-1:0] read_value_reg;
    logic                     landed_reg;
    logic                     saturated_reg;
    logic                     done_reg;

    logic [SIDE_W-1:0]        w_eff;
    logic [SIDE_W-1:0]        h_eff;
    logic [LIN_W-1:0]         area;
    logic signed [OFS_W-1:0]  tx;
    logic signed [OFS_W-1:0]  ty;
    logic                     in_grid;
    logic [LIN_W-1:0]         lin;
    logic                     is_add;

    logic [VALUE_BITS-1:0]    rdata;
    logic signed [PROD_W:0]   rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  clamp_in;
    logic                     ovf;
    logic [VALUE_BITS-1:0]    stored;
    logic                     ram_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg      <= SIDE_W'(1);
            grid_height_reg     <= SIDE_W'(1);
            grid_center_x_reg   <= '0;
            grid_center_y_reg   <= '0;
            stream_width_reg    <= SIDE_W'(1);
            stream_height_reg   <= SIDE_W'(1);
            stream_center_x_reg <= '0;
            stream_center_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_GRID_WIDTH:      grid_width_reg      <= cfg_wdata;
                CFG_GRID_HEIGHT:     grid_height_reg     <= cfg_wdata;
                CFG_GRID_CENTER_X:   grid_center_x_reg   <= cfg_wdata[CENTER_W-1:0];
                CFG_GRID_CENTER_Y:   grid_center_y_reg   <= cfg_wdata[CENTER_W-1:0];
                CFG_STREAM_WIDTH:    stream_width_reg    <= cfg_wdata;
                CFG_STREAM_HEIGHT:   stream_height_reg   <= cfg_wdata;
                CFG_STREAM_CENTER_X: stream_center_x_reg <= cfg_wdata[CENTER_W-1:0];
                CFG_STREAM_CENTER_Y: stream_center_y_reg <= cfg_wdata[CENTER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_t'(req_type);
            idx_reg  <= cell_index;
            val_reg  <= cell_value;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            mag_reg  <= magnitude;
            last_reg <= last_cell;
        end
        if (cmd.resolve)
        begin
            addr_reg <= addr_next;
            hit_reg  <= hit_next;
        end
        if (cmd.fetch)
        begin
            prod_reg <= PROD_W'(val_reg) * PROD_W'(mag_reg);
        end
        if (cmd.commit)
        begin
            read_value_reg <= '0;
            if (hit_reg)
            begin
                if (req_reg == REQ_READ)
                begin
                    read_value_reg <= CELL_W'($signed(rdata));
                end
                else
                begin
                    read_value_reg <= CELL_W'($signed(stored));
                end
            end
            landed_reg    <= hit_reg;
            saturated_reg <= hit_reg && (req_reg != REQ_READ) && ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_col_reg <= '0;
            stream_row_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            stream_col_reg <= stream_col_next;
            stream_row_reg <= stream_row_next;
            done_reg       <= cmd.commit;
        end
    end

    assign is_add = req_reg[1];

    always_comb
    begin
        stream_col_next = stream_col_reg;
        stream_row_next = stream_row_reg;
        if (cmd.resolve && is_add)
        begin
            if (last_reg)
            begin
                stream_col_next = '0;
                stream_row_next = '0;
            end
            else if ((SIDE_W'(stream_col_reg) + SIDE_W'(1) >= stream_width_reg)
                     || (stream_col_reg == '1))
            begin
                stream_col_next = '0;
                if ((SIDE_W'(stream_row_reg) + SIDE_W'(1) >= stream_height_reg)
                    || (stream_row_reg == '1))
                begin
                    stream_row_next = '0;
                end
                else
                begin
                    stream_row_next = stream_row_reg + CTR_W'(1);
                end
            end
            else
            begin
                stream_col_next = stream_col_reg + CTR_W'(1);
            end
        end
    end

    always_comb
    begin
        w_eff = (int'(grid_width_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : grid_width_reg;
        h_eff = (int'(grid_height_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : grid_height_reg;
        area  = LIN_W'(w_eff) * LIN_W'(h_eff);
        if (req_reg == REQ_STAMP)
        begin
            tx = $signed(OFS_W'(stream_col_reg)) + OFS_W'(px_reg)
                 - $signed(OFS_W'(stream_center_x_reg));
            ty = $signed(OFS_W'(stream_row_reg)) + OFS_W'(py_reg)
                 - $signed(OFS_W'(stream_center_y_reg));
        end
        else
        begin
            tx = $signed(OFS_W'(stream_col_reg)) - OFS_W'(px_reg)
                 + $signed(OFS_W'(grid_center_x_reg));
            ty = $signed(OFS_W'(stream_row_reg)) - OFS_W'(py_reg)
                 + $signed(OFS_W'(grid_center_y_reg));
        end
        in_grid = !tx[OFS_W-1] && (tx[OFS_W-2:0] < (OFS_W-1)'(w_eff))
                  && !ty[OFS_W-1] && (ty[OFS_W-2:0] < (OFS_W-1)'(h_eff));
        lin = LIN_W'(tx[SIDE_W-1:0]) + LIN_W'(ty[SIDE_W-1:0]) * LIN_W'(w_eff);
        if (is_add)
        begin
            hit_next  = in_grid;
            addr_next = ADDR_W'(lin);
        end
        else
        begin
            hit_next  = LIN_W'(idx_reg) < area;
            addr_next = ADDR_W'(LIN_W'(idx_reg));
        end
    end

    always_comb
    begin
        rnd  = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(2048);
        term = rnd[PROD_W:RND_SHIFT];
        sum  = SUM_W'($signed(rdata)) + SUM_W'(term);
        if (req_reg == REQ_WRITE)
        begin
            clamp_in = SUM_W'(val_reg);
        end
        else
        begin
            clamp_in = sum;
        end
        ovf = clamp_in[SUM_W-1:VALUE_BITS-1] != {EXT_W{clamp_in[SUM_W-1]}};
        if (!ovf)
        begin
            stored = clamp_in[VALUE_BITS-1:0];
        end
        else if (clamp_in[SUM_W-1])
        begin
            stored = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        else
        begin
            stored = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        ram_we = cmd.commit && hit_reg && (req_reg != REQ_READ);
    end

    cgsa_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.fetch || ram_we),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (stored),
        .rdata (rdata)
    );

    assign read_value = read_value_reg;
    assign landed     = landed_reg;
    assign saturated  = saturated_reg;
    assign done       = done_reg;

endmodule
`default_nettype wire

### rtl/clipped_grid_scaled_accumulate.sv
// Top level of the clipped grid scaled accumulator.
`default_nettype none
// A transfer is accepted when start is high while busy is low; busy then stays high while the
// sequencer resolves the target address, reads the cell from the single-port grid RAM and
// writes the updated cell back, so a new transfer is taken only once the last one is committed.
// The result appears on read_value, landed and saturated with done high for exactly one cycle,
// and is taken at the rising edge that ends that cycle; the receiver cannot stall it and must
// take it then. The grid RAM is not cleared at reset: cells must be written before they are
// read or accumulated. Stamp and gather transfers walk the streamed grid in raster order with
// internal counters that last_cell returns to the origin. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module clipped_grid_scaled_accumulate #(
    parameter int MAX_SIDE   = cgsa_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = cgsa_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [cgsa_pkg::REQ_W-1:0]             req_type,
    input  logic [cgsa_pkg::IDX_W-1:0]             cell_index,
    input  logic signed [cgsa_pkg::CELL_W-1:0]     cell_value,
    input  logic signed [cgsa_pkg::POS_W-1:0]      pos_x,
    input  logic signed [cgsa_pkg::POS_W-1:0]      pos_y,
    input  logic signed [cgsa_pkg::MAG_W-1:0]      magnitude,
    input  logic                                   last_cell,
    output logic                                   done,
    output logic signed [cgsa_pkg::CELL_W-1:0]     read_value,
    output logic                                   landed,
    output logic                                   saturated,
    input  logic                                   cfg_wr_en,
    input  logic [cgsa_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [cgsa_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import cgsa_pkg::*;

    cmd_t cmd;

    cgsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    cgsa_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req_type   (req_type),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .magnitude  (magnitude),
        .last_cell  (last_cell),
        .read_value (read_value),
        .landed     (landed),
        .saturated  (saturated),
        .done       (done)
    );

    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("done did not follow an accepted transfer after four cycles");

    a_done_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done raised without a transfer in progress");

    a_sat_implies_landed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> landed)
        else $error("saturated reported on a transfer that did not land");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !landed) |-> (read_value == '0))
        else $error("nonzero result on a transfer that did not land");

endmodule
`default_nettype wire

### tb/clipped_grid_scaled_accumulate_tb.sv
// Self-checking testbench for the clipped grid scaled accumulator: directed table, then random phases.
module clipped_grid_scaled_accumulate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgsa_pkg::*;

    localparam int STORE_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int PHASES      = 12;
    localparam int PHASE_OPS   = 120;

    typedef struct {
        req_t                     req;
        logic [IDX_W-1:0]         idx;
        logic signed [CELL_W-1:0] val;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [MAG_W-1:0]  mag;
        logic                     last;
    } grid_op_t;

    typedef struct {
        logic signed [CELL_W-1:0] value;
        logic                     landed;
        logic                     sat;
    } cell_result_t;

    typedef struct {
        grid_op_t     op;
        bit           typed;
        cell_result_t res;
    } script_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [REQ_W-1:0]         req_type = '0;
    logic [IDX_W-1:0]         cell_index = '0;
    logic signed [CELL_W-1:0] cell_value = '0;
    logic signed [POS_W-1:0]  pos_x = '0;
    logic signed [POS_W-1:0]  pos_y = '0;
    logic signed [MAG_W-1:0]  magnitude = '0;
    logic                     last_cell = 1'b0;
    logic                     done;
    logic signed [CELL_W-1:0] read_value;
    logic                     landed;
    logic                     saturated;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    clipped_grid_scaled_accumulate dut (.*);

    logic [SIDE_W-1:0]        grid_w = 7'd1;
    logic [SIDE_W-1:0]        grid_h = 7'd1;
    logic [CENTER_W-1:0]      grid_cx = '0;
    logic [CENTER_W-1:0]      grid_cy = '0;
    logic [SIDE_W-1:0]        strm_w = 7'd1;
    logic [SIDE_W-1:0]        strm_h = 7'd1;
    logic [CENTER_W-1:0]      strm_cx = '0;
    logic [CENTER_W-1:0]      strm_cy = '0;
    logic [CTR_W-1:0]         col = '0;
    logic [CTR_W-1:0]         row = '0;
    logic signed [CELL_W-1:0] cells [STORE_CELLS];
    bit                       known [STORE_CELLS];

    cell_result_t pending_results [$];
    int           mismatches = 0;
    int           burst_left = 1;
    int           items_sent = 0;

    script_row_t script [19] = '{
        '{'{REQ_WRITE, 12'd0, 16'sd32767, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd32767, 1'b1, 1'b0}},
        '{'{REQ_READ, 12'd0, 16'sd0, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd32767, 1'b1, 1'b0}},
        '{'{REQ_READ, 12'hFFF, 16'sd0, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_WRITE, 12'd1, 16'sd5, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sd32767, 9'sd0, 9'sd0, 16'sd32767, 1'b0}, 1'b1,
          '{16'sd32767, 1'b1, 1'b1}},
        '{'{REQ_WRITE, 12'd0, 16'sh8000, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sh8000, 1'b1, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sh8000, 9'sd0, 9'sd0, 16'sd32767, 1'b0}, 1'b1,
          '{16'sh8000, 1'b1, 1'b1}},
        '{'{REQ_GATHER, 12'd0, 16'sd100, 9'sd255, 9'sd0, 16'sd4096, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sd100, 9'sh100, 9'sd0, 16'sd4096, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sd100, 9'sd0, 9'sd255, 16'sd4096, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_GATHER, 12'd0, 16'sd100, 9'sd0, 9'sh100, 16'sd4096, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_WRITE, 12'd0, 16'sd0, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd0, 1'b1, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sd1, 9'sd0, 9'sd0, 16'sd2048, 1'b0}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, -16'sd1, 9'sd0, 9'sd0, 16'sd2048, 1'b0}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, -16'sd1, 9'sd0, 9'sd0, 16'sd2049, 1'b0}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_STAMP, 12'd0, 16'sd32767, 9'sd0, 9'sd0, 16'sh8000, 1'b0}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_GATHER, 12'd0, 16'sh8000, 9'sd0, 9'sd0, 16'sh8000, 1'b1}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_READ, 12'd0, 16'sd0, 9'sd0, 9'sd0, 16'sd0, 1'b1}, 1'b0,
          '{16'sd0, 1'b0, 1'b0}},
        '{'{REQ_WRITE, 12'hFFF, 16'shFFFF, 9'sd0, 9'sd0, 16'sd0, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int side_cells(input logic [SIDE_W-1:0] s);
        return (int'(s) > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(s);
    endfunction

    function automatic bit target_of(input grid_op_t op, output int addr);
        int tx;
        int ty;
        int w;
        int h;
        w = side_cells(grid_w);
        h = side_cells(grid_h);
        if (op.req == REQ_STAMP)
        begin
            tx = int'(col) + int'(op.px) - int'(strm_cx);
            ty = int'(row) + int'(op.py) - int'(strm_cy);
        end
        else
        begin
            tx = int'(col) - int'(op.px) + int'(grid_cx);
            ty = int'(row) - int'(op.py) + int'(grid_cy);
        end
        addr = tx + ty * w;
        return tx >= 0 && tx < w && ty >= 0 && ty < h;
    endfunction

    function automatic cell_result_t accumulate_cell(input grid_op_t op);
        cell_result_t r;
        int addr;
        int sum;
        r.value = '0;
        r.landed = 1'b0;
        r.sat = 1'b0;
        if (op.req == REQ_WRITE || op.req == REQ_READ)
        begin
            if (int'(op.idx) < side_cells(grid_w) * side_cells(grid_h))
            begin
                if (op.req == REQ_WRITE)
                begin
                    cells[op.idx] = op.val;
                    known[op.idx] = 1'b1;
                end
                r.value = cells[op.idx];
                r.landed = 1'b1;
            end
        end
        else
        begin
            if (target_of(op, addr))
            begin
                sum = int'(cells[addr]) + ((int'(op.val) * int'(op.mag) + 2048) >>> 12);
                r.sat = sum > 32767 || sum < -32768;
                if (sum > 32767)
                    sum = 32767;
                else if (sum < -32768)
                    sum = -32768;
                cells[addr] = 16'(sum);
                r.value = cells[addr];
                r.landed = 1'b1;
            end
            if (op.last)
            begin
                col = '0;
                row = '0;
            end
            else if (int'(col) + 1 >= int'(strm_w) || col == 6'd63)
            begin
                col = '0;
                if (int'(row) + 1 >= int'(strm_h) || row == 6'd63)
                    row = '0;
                else
                    row = row + CTR_W'(1);
            end
            else
                col = col + CTR_W'(1);
        end
        return r;
    endfunction

    task automatic drive(input grid_op_t op, input bit typed, input cell_result_t given);
        cell_result_t predicted;
        req_type <= op.req;
        cell_index <= op.idx;
        cell_value <= op.val;
        pos_x <= op.px;
        pos_y <= op.py;
        magnitude <= op.mag;
        last_cell <= op.last;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        predicted = accumulate_cell(op);
        pending_results.push_back(typed ? given : predicted);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // A read or an accumulate that would touch a cell never written is preceded by a write to it.
    task automatic send(input grid_op_t op);
        grid_op_t     fill;
        cell_result_t none;
        int           addr;
        bit           need;
        none = '{16'sd0, 1'b0, 1'b0};
        need = 1'b0;
        if (op.req == REQ_READ)
        begin
            addr = int'(op.idx);
            need = addr < side_cells(grid_w) * side_cells(grid_h) && !known[addr];
        end
        else if (op.req != REQ_WRITE)
            need = target_of(op, addr) && !known[addr];
        if (need)
        begin
            fill = op;
            fill.req = REQ_WRITE;
            fill.idx = 12'(addr);
            fill.val = 16'($urandom);
            drive(fill, 1'b0, none);
        end
        drive(op, 1'b0, none);
    endtask

    task automatic wait_idle();
        int n;
        start <= 1'b0;
        for (n = 0; n < 400 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_idx_t which, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= which;
        cfg_wdata <= data;
        @(posedge clk);
        case (which)
            CFG_GRID_WIDTH:      grid_w = data;
            CFG_GRID_HEIGHT:     grid_h = data;
            CFG_GRID_CENTER_X:   grid_cx = data[CENTER_W-1:0];
            CFG_GRID_CENTER_Y:   grid_cy = data[CENTER_W-1:0];
            CFG_STREAM_WIDTH:    strm_w = data;
            CFG_STREAM_HEIGHT:   strm_h = data;
            CFG_STREAM_CENTER_X: strm_cx = data[CENTER_W-1:0];
            CFG_STREAM_CENTER_Y: strm_cy = data[CENTER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int gw, input int gh, input int gcx, input int gcy,
                             input int sw, input int sh, input int scx, input int scy);
        wait_idle();
        set_reg(CFG_GRID_WIDTH, 7'(gw));
        set_reg(CFG_GRID_HEIGHT, 7'(gh));
        set_reg(CFG_GRID_CENTER_X, 7'(gcx));
        set_reg(CFG_GRID_CENTER_Y, 7'(gcy));
        set_reg(CFG_STREAM_WIDTH, 7'(sw));
        set_reg(CFG_STREAM_HEIGHT, 7'(sh));
        set_reg(CFG_STREAM_CENTER_X, 7'(scx));
        set_reg(CFG_STREAM_CENTER_Y, 7'(scy));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int p);
        int                      w;
        int                      h;
        int                      gw;
        int                      gh;
        int                      sw;
        int                      sh;
        int                      sw_e;
        int                      sh_e;
        int                      full;
        int                      len;
        int                      ox;
        int                      oy;
        int                      base;
        int                      i;
        bit                      gather;
        bit                      broken;
        bit                      wild;
        logic signed [MAG_W-1:0] scale;
        grid_op_t                op;
        case (p)
            0: configure(64, 1, 32, 0, 64, 1, 63, 0);
            1: configure(1, 64, 0, 32, 1, 64, 0, 63);
            2: configure(127, 3, 63, 1, 127, 0, 0, 0);
            3: configure(0, 5, 0, 2, 0, 127, 5, 7);
            4: configure(64, 64, 32, 32, 8, 8, 4, 4);
            default:
            begin
                gw = $urandom_range(1, 16);
                gh = $urandom_range(1, 16);
                sw = $urandom_range(1, 8);
                sh = $urandom_range(1, 8);
                configure(gw, gh,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : gw / 2,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : gh / 2,
                          sw, sh,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : sw / 2,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : sh / 2);
            end
        endcase
        w = side_cells(grid_w);
        h = side_cells(grid_h);
        base = items_sent;
        while (items_sent - base < PHASE_OPS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                gather = 1'($urandom_range(0, 1));
                sw_e = (side_cells(strm_w) < 1) ? 1 : side_cells(strm_w);
                sh_e = (side_cells(strm_h) < 1) ? 1 : side_cells(strm_h);
                full = sw_e * sh_e;
                len = (full <= 48) ? full : $urandom_range(8, 48);
                if (len > PHASE_OPS - (items_sent - base))
                    len = PHASE_OPS - (items_sent - base);
                broken = ($urandom_range(0, 6) == 0);
                if (broken)
                    len = $urandom_range(1, len);
                wild = ($urandom_range(0, 9) == 0);
                ox = int'($urandom_range(0, w + sw_e)) - sw_e;
                oy = int'($urandom_range(0, h + sh_e)) - sh_e;
                scale = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'(int'($urandom_range(0, 8191)) - 4096);
                for (i = 0; i < len; i++)
                begin
                    op.req = gather ? REQ_GATHER : REQ_STAMP;
                    op.idx = 12'($urandom);
                    op.val = 16'($urandom);
                    op.px = gather ? 9'(int'(grid_cx) - ox) : 9'(ox + int'(strm_cx));
                    op.py = gather ? 9'(int'(grid_cy) - oy) : 9'(oy + int'(strm_cy));
                    if (wild)
                    begin
                        op.px = 9'($urandom);
                        op.py = 9'($urandom);
                    end
                    op.mag = scale;
                    if (broken)
                        op.last = ($urandom_range(0, 5) == 0);
                    else
                        op.last = (i == len - 1);
                    send(op);
                end
            end
            else
            begin
                op.req = req_t'($urandom_range(0, 3));
                op.idx = (w * h > 0 && $urandom_range(0, 3) != 0) ? 12'($urandom_range(0, w * h - 1))
                                                                   : 12'($urandom);
                op.val = 16'($urandom);
                op.px = 9'($urandom);
                op.py = 9'($urandom);
                op.mag = 16'($urandom);
                op.last = 1'($urandom_range(0, 1));
                send(op);
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        cell_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: value %0d landed %0b saturated %0b",
                             read_value, landed, saturated);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value || landed !== want.landed
                    || saturated !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.value, want.landed, want.sat,
                                 read_value, landed, saturated);
                end
            end
        end
    end

    initial
    begin
        #1ms;
        $display("clipped_grid_scaled_accumulate regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
            drive(script[i].op, script[i].typed, script[i].res);
        for (p = 0; p < PHASES; p++)
            run_phase(p);
        wait_idle();
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("clipped_grid_scaled_accumulate regression: pass");
        else
            $display("clipped_grid_scaled_accumulate regression: fail");
        $finish;
    end
endmodule
